// ===== design/pidpi_pkg.sv =====
// ----------------------------------------------------------------------------
// pidpi_pkg: shared constants and codes of the pid controller
// defaults for the number format, register indexes and mode codes
// ----------------------------------------------------------------------------
package pidpi_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // register index port width
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE_SELECT  = 3'd0,
        CFG_GAIN_P       = 3'd1,
        CFG_GAIN_I       = 3'd2,
        CFG_GAIN_D       = 3'd3,
        CFG_DRIVE_MAX    = 3'd4,
        CFG_DRIVE_MIN    = 3'd5,
        CFG_INTEGRAL_MAX = 3'd6,
        CFG_INTEGRAL_MIN = 3'd7
    } cfg_index_t;

    typedef enum logic {
        MODE_POSITIONAL  = 1'b0,
        MODE_INCREMENTAL = 1'b1
    } mode_t;

endpackage

// ===== design/pidpi_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pidpi_cfg_regs: configuration register file
// write-only registers for mode, gains and clamp limits
// ----------------------------------------------------------------------------
module pidpi_cfg_regs
    import pidpi_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wen,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [DATA_WIDTH-1:0]        cfg_wdata,
    output mode_t                        mode,
    output logic signed [DATA_WIDTH-1:0] gain_p,
    output logic signed [DATA_WIDTH-1:0] gain_i,
    output logic signed [DATA_WIDTH-1:0] gain_d,
    output logic signed [DATA_WIDTH-1:0] drive_max,
    output logic signed [DATA_WIDTH-1:0] drive_min,
    output logic signed [DATA_WIDTH-1:0] integral_max,
    output logic signed [DATA_WIDTH-1:0] integral_min
);

    localparam logic [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    mode_t                 mode_reg;
    logic [DATA_WIDTH-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [DATA_WIDTH-1:0] drive_max_reg, drive_min_reg;
    logic [DATA_WIDTH-1:0] integral_max_reg, integral_min_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_POSITIONAL;
            gain_p_reg       <= '0;
            gain_i_reg       <= '0;
            gain_d_reg       <= '0;
            drive_max_reg    <= SMAX;
            drive_min_reg    <= SMIN;
            integral_max_reg <= SMAX;
            integral_min_reg <= SMIN;
        end else if (cfg_wen) begin
            case (cfg_index_t'(cfg_index))
                CFG_MODE_SELECT:  mode_reg         <= mode_t'(cfg_wdata[0]);
                CFG_GAIN_P:       gain_p_reg       <= cfg_wdata;
                CFG_GAIN_I:       gain_i_reg       <= cfg_wdata;
                CFG_GAIN_D:       gain_d_reg       <= cfg_wdata;
                CFG_DRIVE_MAX:    drive_max_reg    <= cfg_wdata;
                CFG_DRIVE_MIN:    drive_min_reg    <= cfg_wdata;
                CFG_INTEGRAL_MAX: integral_max_reg <= cfg_wdata;
                CFG_INTEGRAL_MIN: integral_min_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign mode         = mode_reg;
    assign gain_p       = $signed(gain_p_reg);
    assign gain_i       = $signed(gain_i_reg);
    assign gain_d       = $signed(gain_d_reg);
    assign drive_max    = $signed(drive_max_reg);
    assign drive_min    = $signed(drive_min_reg);
    assign integral_max = $signed(integral_max_reg);
    assign integral_min = $signed(integral_min_reg);

endmodule

// ===== design/pidpi_fmul.sv =====
// ----------------------------------------------------------------------------
// pidpi_fmul: fixed point multiplier
// full signed product, floor shift by the fraction bits, saturation
// ----------------------------------------------------------------------------
module pidpi_fmul
    import pidpi_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic signed [DATA_WIDTH-1:0] a,
    input  logic signed [DATA_WIDTH-1:0] b,
    output logic signed [DATA_WIDTH-1:0] y
);

    localparam int PW = 2 * DATA_WIDTH;
    localparam int QW = PW - FRAC_BITS;

    logic signed [PW-1:0] prod;
    logic        [QW-1:0] quot;
    logic                 fits;

    always_comb begin
        prod = (PW)'(a) * (PW)'(b);
        // arithmetic shift right, rounds toward minus infinity
        quot = prod[PW-1:FRAC_BITS];
        // in range when all bits from the target sign bit up agree
        fits = (&quot[QW-1:DATA_WIDTH-1]) | ~(|quot[QW-1:DATA_WIDTH-1]);
        if (fits) begin
            y = $signed(quot[DATA_WIDTH-1:0]);
        end else if (quot[QW-1]) begin
            y = $signed({1'b1, {(DATA_WIDTH-1){1'b0}}});
        end else begin
            y = $signed({1'b0, {(DATA_WIDTH-1){1'b1}}});
        end
    end

endmodule

// ===== design/pidpi_core.sv =====
// ----------------------------------------------------------------------------
// pidpi_core: pid arithmetic for one sample
// error, differences, three products, sums and clamps in one pass
// ----------------------------------------------------------------------------
module pidpi_core
    import pidpi_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  mode_t                        mode,
    input  logic signed [DATA_WIDTH-1:0] gain_p,
    input  logic signed [DATA_WIDTH-1:0] gain_i,
    input  logic signed [DATA_WIDTH-1:0] gain_d,
    input  logic signed [DATA_WIDTH-1:0] drive_max,
    input  logic signed [DATA_WIDTH-1:0] drive_min,
    input  logic signed [DATA_WIDTH-1:0] integral_max,
    input  logic signed [DATA_WIDTH-1:0] integral_min,
    input  logic signed [DATA_WIDTH-1:0] setpoint,
    input  logic signed [DATA_WIDTH-1:0] measured,
    input  logic signed [DATA_WIDTH-1:0] error_last,
    input  logic signed [DATA_WIDTH-1:0] error_before_last,
    input  logic signed [DATA_WIDTH-1:0] integral_acc,
    input  logic signed [DATA_WIDTH-1:0] drive_last,
    output logic signed [DATA_WIDTH-1:0] error_now,
    output logic signed [DATA_WIDTH-1:0] drive,
    output logic signed [DATA_WIDTH-1:0] p_term,
    output logic signed [DATA_WIDTH-1:0] i_term,
    output logic signed [DATA_WIDTH-1:0] d_term
);

    localparam int W = DATA_WIDTH;

    // saturate a value with one or two guard bits to W bits
    function automatic logic signed [W-1:0] sat1(input logic signed [W:0] x);
        logic signed [W-1:0] r;
        if (x[W] == x[W-1]) begin
            r = $signed(x[W-1:0]);
        end else begin
            r = $signed({x[W], {(W-1){~x[W]}}});
        end
        return r;
    endfunction

    function automatic logic signed [W-1:0] sat2(input logic signed [W+1:0] x);
        logic signed [W-1:0] r;
        if ((&x[W+1:W-1]) | ~(|x[W+1:W-1])) begin
            r = $signed(x[W-1:0]);
        end else begin
            r = $signed({x[W+1], {(W-1){~x[W+1]}}});
        end
        return r;
    endfunction

    // upper limit tested first; inverted limits give hi above hi, else lo
    function automatic logic signed [W-1:0] clamp_w(
        input logic signed [W-1:0] x,
        input logic signed [W-1:0] lo,
        input logic signed [W-1:0] hi
    );
        logic signed [W-1:0] r;
        if (x > hi) begin
            r = hi;
        end else if (x < lo) begin
            r = lo;
        end else begin
            r = x;
        end
        return r;
    endfunction

    logic signed [W-1:0] err;
    logic signed [W-1:0] diff1;
    logic signed [W-1:0] diff2;
    logic signed [W-1:0] p_op, d_op;
    logic signed [W-1:0] p_prod, i_prod, d_prod;
    logic signed [W-1:0] i_pos;
    logic signed [W-1:0] sum_pos, sum_inc, sum_sel;

    always_comb begin
        err   = sat1((W+1)'(setpoint) - (W+1)'(measured));
        diff1 = sat1((W+1)'(err) - (W+1)'(error_last));
        diff2 = sat2((W+2)'(err) - ((W+2)'(error_last) <<< 1)
                     + (W+2)'(error_before_last));
        if (mode == MODE_INCREMENTAL) begin
            p_op = diff1;
            d_op = diff2;
        end else begin
            p_op = err;
            d_op = diff1;
        end
    end

    pidpi_fmul #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul_p (
        .a(gain_p), .b(p_op), .y(p_prod)
    );
    pidpi_fmul #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul_i (
        .a(gain_i), .b(err), .y(i_prod)
    );
    pidpi_fmul #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul_d (
        .a(gain_d), .b(d_op), .y(d_prod)
    );

    always_comb begin
        i_pos   = clamp_w(sat1((W+1)'(integral_acc) + (W+1)'(i_prod)),
                          integral_min, integral_max);
        sum_pos = sat2((W+2)'(p_prod) + (W+2)'(i_pos) + (W+2)'(d_prod));
        // a sum of four W-bit values fits in W+2 bits
        sum_inc = sat2((W+2)'(drive_last) + (W+2)'(p_prod)
                       + (W+2)'(i_prod) + (W+2)'(d_prod));
        if (mode == MODE_INCREMENTAL) begin
            sum_sel = sum_inc;
            i_term  = i_prod;
        end else begin
            sum_sel = sum_pos;
            i_term  = i_pos;
        end
        drive     = clamp_w(sum_sel, drive_min, drive_max);
        p_term    = p_prod;
        d_term    = d_prod;
        error_now = err;
    end

endmodule

// ===== design/pid_position_and_incremental.sv =====
// ----------------------------------------------------------------------------
// pid_position_and_incremental: positional / incremental pid controller
// streaming pid with signed fixed point gains, integral and drive clamps
// ----------------------------------------------------------------------------
// Each input beat carries a setpoint and a measurement; each accepted beat
// gives exactly one result beat with the clamped drive and the p, i and d
// terms of that step. The block takes one beat per clock while the output
// register is free or being read: a beat waits in the input register while
// the error, the three gain products and the sums and clamps are formed,
// and its result moves into the output register as soon as that register is
// free or being read. The per-cycle rate is set by this single pass
// through the three multipliers, which also updates the error history, the
// integral and the last drive for the next beat. While a result is held by
// m_tready low, one more beat can still be taken into the input register.
// Mode, gains and limits are to be written through the cfg port only while
// the block is idle; the block does not enforce this. There is no read-back.
// ----------------------------------------------------------------------------
module pid_position_and_incremental
    import pidpi_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int S_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8,
    parameter int M_TDATA_W  = ((4 * DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DATA_WIDTH-1:0]  cfg_wdata,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // setpoint, measured
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata    // drive, p_term, i_term, d_term
);

    localparam int W = DATA_WIDTH;

    // configuration
    mode_t               mode;
    logic signed [W-1:0] gain_p, gain_i, gain_d;
    logic signed [W-1:0] drive_max, drive_min, integral_max, integral_min;

    pidpi_cfg_regs #(.DATA_WIDTH(W)) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .mode         (mode),
        .gain_p       (gain_p),
        .gain_i       (gain_i),
        .gain_d       (gain_d),
        .drive_max    (drive_max),
        .drive_min    (drive_min),
        .integral_max (integral_max),
        .integral_min (integral_min)
    );

    // handshake control
    logic in_valid_reg, in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic s_beat;
    logic advance;      // input register moves into the output register

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_beat   = s_tvalid && s_tready;

    always_comb begin
        if (s_beat) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register: payload only, captured on each input beat
    logic signed [W-1:0] setpoint_reg, measured_reg;

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            setpoint_reg <= $signed(s_tdata[W-1:0]);
            measured_reg <= $signed(s_tdata[2*W-1:W]);
        end
    end

    // controller state, updated once per sample as it leaves the input register
    logic signed [W-1:0] error_last_reg, error_before_last_reg;
    logic signed [W-1:0] integral_acc_reg, drive_last_reg;

    // single-pass arithmetic
    logic signed [W-1:0] error_now, drive, p_term, i_term, d_term;

    pidpi_core #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_core (
        .mode              (mode),
        .gain_p            (gain_p),
        .gain_i            (gain_i),
        .gain_d            (gain_d),
        .drive_max         (drive_max),
        .drive_min         (drive_min),
        .integral_max      (integral_max),
        .integral_min      (integral_min),
        .setpoint          (setpoint_reg),
        .measured          (measured_reg),
        .error_last        (error_last_reg),
        .error_before_last (error_before_last_reg),
        .integral_acc      (integral_acc_reg),
        .drive_last        (drive_last_reg),
        .error_now         (error_now),
        .drive             (drive),
        .p_term            (p_term),
        .i_term            (i_term),
        .d_term            (d_term)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_last_reg        <= '0;
            error_before_last_reg <= '0;
            integral_acc_reg      <= '0;
            drive_last_reg        <= '0;
        end else if (advance) begin
            error_last_reg        <= error_now;
            error_before_last_reg <= error_last_reg;
            integral_acc_reg      <= i_term;    // incremental mode overwrites it
            drive_last_reg        <= drive;
        end
    end

    // output register: payload only
    logic signed [W-1:0] drive_reg, p_term_reg, i_term_reg, d_term_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            drive_reg  <= drive;
            p_term_reg <= p_term;
            i_term_reg <= i_term;
            d_term_reg <= d_term;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({d_term_reg, i_term_reg, p_term_reg, drive_reg});

    // assertions
    // a waiting sample is not dropped while the output is stalled
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_tready |=> in_valid_reg)
        else $error("input register lost a sample during output stall");

    // error history shifts by one sample on each pass
    a_err_hist: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> error_before_last_reg == $past(error_last_reg)
                    && error_last_reg == $past(error_now))
        else $error("error history not shifted");

    // the remembered drive and integral match the result just registered for output
    a_drive_last: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> drive_last_reg == drive_reg && integral_acc_reg == i_term_reg)
        else $error("stored drive or integral differs from result");

    // positional integral stays inside ordered limits
    a_int_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && mode == MODE_POSITIONAL && integral_min <= integral_max
        |=> i_term_reg <= $past(integral_max) && i_term_reg >= $past(integral_min))
        else $error("positional integral outside limits");

    // drive stays inside ordered limits
    a_drive_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && drive_min <= drive_max
        |=> drive_reg <= $past(drive_max) && drive_reg >= $past(drive_min))
        else $error("drive outside limits");

endmodule

// ===== bench/pid_drive_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_drive_monitor: result predictor and comparator for the pid controller
// watches the cfg port and both streams, predicts each result beat and
// compares it field by field with what the block delivers
// ----------------------------------------------------------------------------
module pid_drive_monitor
    import pidpi_pkg::*;
#(
    parameter int W         = DATA_WIDTH_DEF,
    parameter int FRAC      = FRAC_BITS_DEF,
    parameter int S_TDATA_W = ((2 * W + 7) / 8) * 8,
    parameter int M_TDATA_W = ((4 * W + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [W-1:0]           cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // setpoint, measured
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,   // drive, p_term, i_term, d_term
    output int                     mismatch_count,
    output int                     pending_count
);

    localparam longint SMAX = (longint'(1) <<< (W - 1)) - 1;
    localparam longint SMIN = -SMAX - 1;

    // first member sits in the top bits
    typedef struct packed {
        logic signed [W-1:0] d_term;
        logic signed [W-1:0] i_term;
        logic signed [W-1:0] p_term;
        logic signed [W-1:0] drive;
    } pid_result_t;

    mode_t               mode;
    logic signed [W-1:0] gain_p, gain_i, gain_d;
    logic signed [W-1:0] drive_max, drive_min, integral_max, integral_min;
    logic signed [W-1:0] err_last, err_prev, integ_acc, drive_prev;

    pid_result_t expected_results[$];
    int          mismatches = 0;
    int          waiting    = 0;

    assign mismatch_count = mismatches;
    assign pending_count  = waiting;

    function automatic longint saturate(longint x);
        if (x > SMAX) return SMAX;
        if (x < SMIN) return SMIN;
        return x;
    endfunction

    // upper limit tested first, so inverted limits resolve as the block does
    function automatic longint bound(longint x, longint lo, longint hi);
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    // exact product, floor shift, saturate
    function automatic longint scale(longint gain, longint value);
        longint prod;
        prod = (gain * value) >>> FRAC;
        return saturate(prod);
    endfunction

    function automatic pid_result_t advance_controller(logic signed [W-1:0] setpoint,
                                                      logic signed [W-1:0] measured);
        longint      err, e1, e2, p, i, d, sum;
        pid_result_t r;
        err = saturate(longint'(setpoint) - longint'(measured));
        e1  = longint'(err_last);
        e2  = longint'(err_prev);
        if (mode == MODE_POSITIONAL) begin
            p   = scale(gain_p, err);
            d   = scale(gain_d, saturate(err - e1));
            i   = bound(saturate(longint'(integ_acc) + scale(gain_i, err)),
                        integral_min, integral_max);
            sum = saturate(p + i + d);
        end else begin
            p   = scale(gain_p, saturate(err - e1));
            i   = scale(gain_i, err);
            d   = scale(gain_d, saturate(err - 2 * e1 + e2));
            sum = saturate(longint'(drive_prev) + p + i + d);
        end
        sum        = bound(sum, drive_min, drive_max);
        integ_acc  = W'(i);
        err_prev   = W'(e1);
        err_last   = W'(err);
        drive_prev = W'(sum);
        r.drive    = W'(sum);
        r.p_term   = W'(p);
        r.i_term   = W'(i);
        r.d_term   = W'(d);
        return r;
    endfunction

    task automatic compare_field(input string label, input logic [W-1:0] want,
                                 input logic [W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch_edge
        pid_result_t got, want;
        if (!aresetn) begin
            mode         = MODE_POSITIONAL;
            gain_p       = '0;
            gain_i       = '0;
            gain_d       = '0;
            drive_max    = W'(SMAX);
            drive_min    = W'(SMIN);
            integral_max = W'(SMAX);
            integral_min = W'(SMIN);
            err_last     = '0;
            err_prev     = '0;
            integ_acc    = '0;
            drive_prev   = '0;
            expected_results.delete();
        end else begin
            if (cfg_wen) begin
                case (cfg_index_t'(cfg_index))
                    CFG_MODE_SELECT:  mode = mode_t'(cfg_wdata[0]);
                    CFG_GAIN_P:       gain_p = cfg_wdata;
                    CFG_GAIN_I:       gain_i = cfg_wdata;
                    CFG_GAIN_D:       gain_d = cfg_wdata;
                    CFG_DRIVE_MAX:    drive_max = cfg_wdata;
                    CFG_DRIVE_MIN:    drive_min = cfg_wdata;
                    CFG_INTEGRAL_MAX: integral_max = cfg_wdata;
                    CFG_INTEGRAL_MIN: integral_min = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(advance_controller(s_tdata[W-1:0],
                                                              s_tdata[2*W-1:W]));
            if (m_tvalid && m_tready) begin
                got = m_tdata[4*W-1:0];
                if (expected_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got %h", $time, got);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("drive", want.drive, got.drive);
                    compare_field("p_term", want.p_term, got.p_term);
                    compare_field("i_term", want.i_term, got.i_term);
                    compare_field("d_term", want.d_term, got.d_term);
                end
            end
        end
        waiting = expected_results.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench of the positional / incremental pid controller
// directed beats at the field and limit extremes in both modes, then random
// settings with random samples under random stalls on both streams
// ----------------------------------------------------------------------------
module tb;
    import pidpi_pkg::*;

    localparam int W         = DATA_WIDTH_DEF;
    localparam int S_TDATA_W = ((2 * W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((4 * W + 7) / 8) * 8;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 8;
    // extra pause once every result has come back
    localparam int SETTLE_CYCLES   = 6;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int HOLD_OFF_CYCLES = 300;
    // cycles with no beat, no write: well above hold-off plus longest gaps
    localparam int WATCHDOG_LIMIT  = 3000;

    localparam logic [W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic [W-1:0] Q_ONE = 32'h0001_0000;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wen;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [W-1:0]           cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;   // setpoint, measured
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;   // drive, p_term, i_term, d_term

    int mismatch_count;
    int pending_count;
    int quiet_cycles;

    // idling switches per phase, and the one-shot long receiver hold-off
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_off;

    pid_position_and_incremental i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    pid_drive_monitor i_drive_monitor (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wen        (cfg_wen),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sample value: extremes, full range, or small around zero
    function automatic logic [W-1:0] pick_value();
        int r;
        logic [W-1:0] v;
        r = $urandom_range(0, 15);
        if (r == 0) return Q_MAX;
        if (r == 1) return Q_MIN;
        if (r < 6) return $urandom;
        v = $urandom_range(0, 32'h0004_0000);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // gain: mostly a few units either way, sometimes extreme, zero or full range
    function automatic logic [W-1:0] pick_gain();
        int r;
        logic [W-1:0] v;
        r = $urandom_range(0, 15);
        if (r == 0) return Q_MAX;
        if (r == 1) return Q_MIN;
        if (r == 2) return '0;
        if (r < 5) return $urandom;
        v = $urandom_range(0, 32'h0004_0000);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // limit pair: defaults, inverted, or a random window around zero
    task automatic pick_limits(output logic [W-1:0] hi, output logic [W-1:0] lo);
        int r;
        r = $urandom_range(0, 7);
        if (r < 2) begin
            hi = Q_MAX;
            lo = Q_MIN;
        end else if (r == 2) begin
            hi = -$urandom_range(0, 32'h0010_0000);
            lo = $urandom_range(0, 32'h0010_0000);
        end else begin
            hi = $urandom_range(0, 32'h0100_0000);
            lo = -$urandom_range(0, 32'h0100_0000);
        end
    endtask

    // one input beat, with an optional gap before it
    task automatic send_sample(input logic [W-1:0] setpoint, input logic [W-1:0] measured);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {measured, setpoint};
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering and wait until every result has come back
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [W-1:0] value);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
    endtask

    // writes every register, only once the block has drained
    task automatic program_setting(input logic [W-1:0] mode_word,
                                   input logic [W-1:0] kp, input logic [W-1:0] ki,
                                   input logic [W-1:0] kd,
                                   input logic [W-1:0] dmax, input logic [W-1:0] dmin,
                                   input logic [W-1:0] imax, input logic [W-1:0] imin);
        settle();
        write_reg(CFG_MODE_SELECT, mode_word);
        write_reg(CFG_GAIN_P, kp);
        write_reg(CFG_GAIN_I, ki);
        write_reg(CFG_GAIN_D, kd);
        write_reg(CFG_DRIVE_MAX, dmax);
        write_reg(CFG_DRIVE_MIN, dmin);
        write_reg(CFG_INTEGRAL_MAX, imax);
        write_reg(CFG_INTEGRAL_MIN, imin);
        @(negedge aclk);
        cfg_wen <= 1'b0;
    endtask

    task automatic program_random_setting(input int phase);
        logic [W-1:0] dmax, dmin, imax, imin;
        if (phase == 0) begin
            // largest gains, widest limits
            program_setting($urandom, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        end else if (phase == RANDOM_PHASES - 1) begin
            // most negative gains, tight inverted limits
            program_setting($urandom, Q_MIN, Q_MIN, Q_MIN,
                            -Q_ONE, Q_ONE, -(Q_ONE << 1), Q_ONE << 1);
        end else begin
            pick_limits(dmax, dmin);
            pick_limits(imax, imin);
            program_setting($urandom, pick_gain(), pick_gain(), pick_gain(),
                            dmax, dmin, imax, imin);
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int gap_left;
        bit hold_off_done;
        gap_left      = 0;
        hold_off_done = 1'b0;
        m_tready      = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off && !hold_off_done) begin
                // counted here while the sender keeps offering beats
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_done = 1'b1;
                gap_left = 0;
            end else if (gap_left > 0) begin
                m_tready <= 1'b0;
                gap_left--;
            end else begin
                m_tready <= 1'b1;
                if (rx_idle_on)
                    gap_left = pick_gap();
            end
        end
    end

    // watchdog: cycles without any beat or register write
    always @(posedge aclk) begin
        if (!aresetn || cfg_wen || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("pid_position_and_incremental regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        aresetn      = 1'b0;
        cfg_wen      = 1'b0;
        cfg_index    = CFG_MODE_SELECT;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        hold_off     = 1'b0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // positional, unit p gain, d gain minus one, half i gain: error saturation both ways,
        // negative product rounding, first difference saturation, integral running up
        program_setting(32'h0000_0000, Q_ONE, 32'h0000_8000, 32'hFFFF_0000,
                        Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        send_sample(Q_MAX, Q_MIN);
        send_sample(Q_MIN, Q_MAX);
        send_sample('0, '0);
        send_sample(32'hFFFF_FFFF, '0);
        send_sample(Q_MAX, Q_MAX);
        send_sample(Q_MIN, Q_MIN);
        send_sample(32'h0003_0000, 32'hFFFE_8000);

        // extreme gains, inverted drive and integral limits; mode word with
        // high bits set and low bit clear still means positional
        program_setting(32'hFFFF_FFFE, Q_MAX, Q_MIN, Q_MAX,
                        32'hFFFF_0000, Q_ONE, 32'hFFFE_0000, 32'h0002_0000);
        send_sample(Q_ONE, '0);
        send_sample('0, Q_ONE);
        send_sample(Q_MAX, Q_MIN);
        send_sample(32'h0000_0001, '0);
        send_sample('0, 32'h0000_0001);

        // incremental: second difference swings, drive clamped
        program_setting(32'h0000_0003, 32'h0002_0000, 32'h0000_4000, 32'hFFFF_8000,
                        32'h0100_0000, 32'hFF00_0000, Q_MAX, Q_MIN);
        send_sample(Q_ONE, '0);
        send_sample(Q_MAX, Q_MIN);
        send_sample(Q_MIN, Q_MAX);
        send_sample(Q_MAX, Q_MIN);
        send_sample('0, '0);
        send_sample(32'hFFFF_FFFF, 32'h0000_0001);

        // back to positional: integral starts from the incremental ki*e
        program_setting(32'hFFFF_FFF0, 32'h0002_0000, 32'h0000_4000, 32'hFFFF_8000,
                        32'h0100_0000, 32'hFF00_0000, Q_MAX, Q_MIN);
        send_sample('0, '0);
        send_sample(Q_ONE, '0);
        send_sample('0, Q_ONE);

        // random settings; some phases without idling on one side
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            program_random_setting(phase);
            tx_idle_on = (phase % 4) != 1;
            rx_idle_on = (phase % 4) != 2;
            if (phase == 3)
                hold_off = 1'b1;
            repeat (ITEMS_PER_PHASE) send_sample(pick_value(), pick_value());
        end

        settle();
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("pid_position_and_incremental regression: pass");
        end else begin
            $display("pid_position_and_incremental regression: fail");
        end
        $finish;
    end

endmodule

// ===== pid_position_and_incremental.f =====
design/pidpi_pkg.sv
design/pidpi_cfg_regs.sv
design/pidpi_fmul.sv
design/pidpi_core.sv
design/pid_position_and_incremental.sv
bench/pid_drive_monitor.sv
bench/tb.sv
